// File: rtl/sahy_pkg.sv
// Shared types and constants for the speed area selector.
// Used by the front, queue, back and top-level files; depends on nothing.

package sahy_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ODOMETRY = 2'd1,
        OP_READBACK = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_READY   = 2'd2
    } t_mode;

    localparam logic [1:0] AREA_0 = 2'd0;
    localparam logic [1:0] AREA_1 = 2'd1;
    localparam logic [1:0] AREA_2 = 2'd2;

    localparam logic [2:0] REG_SPEED_LIMIT_LOW  = 3'd0;
    localparam logic [2:0] REG_SPEED_LIMIT_HIGH = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS_LOW   = 3'd2;
    localparam logic [2:0] REG_HYSTERESIS_HIGH  = 3'd3;
    localparam logic [2:0] REG_OUTPUT_NUMBER_A  = 3'd4;
    localparam logic [2:0] REG_OUTPUT_NUMBER_B  = 3'd5;
    localparam logic [2:0] REG_ACTIVE_LEVELS    = 3'd6;
    localparam logic [2:0] REG_STALE_TICKS      = 3'd7;

    localparam int unsigned SpeedLowRst  = 200;
    localparam int unsigned SpeedHighRst = 400;
    localparam int unsigned HystLowRst   = 50;
    localparam int unsigned HystHighRst  = 300;

    localparam logic [14:0] SPEED_LOW_RST  = 15'(SpeedLowRst);
    localparam logic [14:0] SPEED_HIGH_RST = 15'(SpeedHighRst);
    localparam logic [14:0] HYST_LOW_RST   = 15'(HystLowRst);
    localparam logic [14:0] HYST_HIGH_RST  = 15'(HystHighRst);
    localparam logic [29:0] LOW_SQ_RST     = 30'(SpeedLowRst * SpeedLowRst);
    localparam logic [29:0] HIGH_SQ_RST    = 30'(SpeedHighRst * SpeedHighRst);
    localparam logic [29:0] LOW_FALL_SQ_RST =
        30'((SpeedLowRst - HystLowRst) * (SpeedLowRst - HystLowRst));
    localparam logic [29:0] HIGH_FALL_SQ_RST =
        30'((SpeedHighRst - HystHighRst) * (SpeedHighRst - HystHighRst));
    localparam logic [3:0]  NUMBER_A_RST   = 4'd1;
    localparam logic [3:0]  NUMBER_B_RST   = 4'd2;
    localparam logic [1:0]  LEVELS_RST     = 2'd3;
    localparam logic [15:0] STALE_RST      = 16'd20;
    localparam logic [15:0] AGE_MAX        = 16'hFFFF;

    localparam int unsigned QDepth = 2;
    localparam int unsigned QAw    = 1;

    // Classified item as it travels from front to back.
    typedef struct packed {
        t_op         op;
        logic [30:0] sq_x;
        logic [30:0] sq_y;
        logic [7:0]  readback;
    } t_item;

    // Configuration as the back sees it, thresholds already squared.
    typedef struct packed {
        logic [29:0] low_sq;
        logic [29:0] high_sq;
        logic [29:0] low_fall_sq;
        logic        low_fall_en;
        logic [29:0] high_fall_sq;
        logic        high_fall_en;
        logic [3:0]  number_a;
        logic [3:0]  number_b;
        logic [1:0]  levels;
        logic [15:0] stale_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] area;
        t_mode      mode;
        logic       wa_req;
        logic [3:0] wa_num;
        logic       wa_lvl;
        logic       wb_req;
        logic [3:0] wb_num;
        logic       wb_lvl;
    } t_result;

endpackage

// File: rtl/sahy_front.sv
// Front stage: accepts input beats, classifies the command and squares the speeds.
// Depends on sahy_pkg.

module sahy_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic signed [15:0] i_speed_x,
    input  logic signed [15:0] i_speed_y,
    input  logic [7:0]        i_output_readback,
    input  logic              i_q_full,
    output logic              o_push,
    output sahy_pkg::t_item   o_item
);

    logic              r_valid;
    sahy_pkg::t_item   r_item;
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic              w_accept;

    assign w_px     = i_speed_x * i_speed_x;
    assign w_py     = i_speed_y * i_speed_y;
    assign o_stall  = r_valid & i_q_full;
    assign w_accept = i_valid & ~o_stall;
    assign o_push   = r_valid & ~i_q_full;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (w_accept) begin
            r_item.op       <= sahy_pkg::t_op'(i_cmd);
            r_item.sq_x     <= w_px[30:0];
            r_item.sq_y     <= w_py[30:0];
            r_item.readback <= i_output_readback;
        end
    end

endmodule

// File: rtl/sahy_queue.sv
// Two-entry queue between front and back.
// Depends on sahy_pkg.

module sahy_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sahy_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sahy_pkg::t_item o_item
);

    localparam int unsigned  QAw      = sahy_pkg::QAw;
    localparam logic [QAw:0] DepthCnt = (QAw + 1)'(sahy_pkg::QDepth);

    sahy_pkg::t_item  r_mem [sahy_pkg::QDepth];
    logic [QAw-1:0]   r_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr;
    logic [QAw:0]     r_count;

    assign o_full  = (r_count == DepthCnt);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/sahy_back.sv
// Back stage: mode and area state, staleness ages, write requests, output register.
// Depends on sahy_pkg.

module sahy_back #(
    parameter int OUTPUT_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  sahy_pkg::t_item   i_item,
    output logic              o_pop,
    input  sahy_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_stall,
    output sahy_pkg::t_result o_res
);

    localparam logic [7:0] CountLimit = 8'(OUTPUT_COUNT);

    sahy_pkg::t_mode   r_mode, n_mode;
    logic [1:0]        r_area, n_area;
    logic [31:0]       r_v2, n_v2;
    logic [7:0]        r_rb, n_rb;
    logic [15:0]       r_odo_age, n_odo_age;
    logic [15:0]       r_rb_age, n_rb_age;
    logic              r_valid;
    sahy_pkg::t_result r_res;
    sahy_pkg::t_result n_res;

    logic        w_fresh;
    logic        w_hold;
    logic        w_lva, w_lvb;
    logic        w_above_hi, w_above_lo, w_below_lo, w_below_hi;
    logic [15:0] w_rb_ext;
    logic        w_num_a_ok, w_num_b_ok;
    logic        w_bit_a, w_bit_b;
    logic [15:0] w_odo_inc, w_rb_inc;

    assign o_pop   = i_q_valid & (~r_valid | ~i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    assign w_odo_inc = (r_odo_age == sahy_pkg::AGE_MAX) ? r_odo_age : r_odo_age + 16'd1;
    assign w_rb_inc  = (r_rb_age == sahy_pkg::AGE_MAX) ? r_rb_age : r_rb_age + 16'd1;
    assign w_fresh   = (w_odo_inc != sahy_pkg::AGE_MAX) && (w_odo_inc <= i_cfg.stale_ticks)
                    && (w_rb_inc != sahy_pkg::AGE_MAX) && (w_rb_inc <= i_cfg.stale_ticks);

    assign w_above_hi = r_v2 > {2'b00, i_cfg.high_sq};
    assign w_above_lo = r_v2 > {2'b00, i_cfg.low_sq};
    assign w_below_lo = i_cfg.low_fall_en & (r_v2 < {2'b00, i_cfg.low_fall_sq});
    assign w_below_hi = i_cfg.high_fall_en & (r_v2 < {2'b00, i_cfg.high_fall_sq});

    // Out-of-range numbers never request; bits above the readback byte read low.
    assign w_rb_ext   = {8'h00, r_rb};
    assign w_num_a_ok = (i_cfg.number_a != 4'd0) && ({4'h0, i_cfg.number_a} <= CountLimit);
    assign w_num_b_ok = (i_cfg.number_b != 4'd0) && ({4'h0, i_cfg.number_b} <= CountLimit);
    assign w_bit_a    = w_rb_ext[i_cfg.number_a - 4'd1];
    assign w_bit_b    = w_rb_ext[i_cfg.number_b - 4'd1];

    always_comb begin
        n_mode    = r_mode;
        n_area    = r_area;
        n_v2      = r_v2;
        n_rb      = r_rb;
        n_odo_age = r_odo_age;
        n_rb_age  = r_rb_age;
        w_hold    = 1'b0;
        w_lva     = 1'b0;
        w_lvb     = 1'b0;
        case (i_item.op)
            sahy_pkg::OP_ODOMETRY: begin
                n_v2      = {1'b0, i_item.sq_x} + {1'b0, i_item.sq_y};
                n_odo_age = 16'd0;
            end
            sahy_pkg::OP_READBACK: begin
                n_rb     = i_item.readback;
                n_rb_age = 16'd0;
            end
            sahy_pkg::OP_TICK: begin
                n_odo_age = w_odo_inc;
                n_rb_age  = w_rb_inc;
                case (r_mode)
                    sahy_pkg::MODE_STANDBY: begin
                        if (w_fresh) n_mode = sahy_pkg::MODE_READY;
                    end
                    sahy_pkg::MODE_READY: begin
                        if (!w_fresh) begin
                            n_mode = sahy_pkg::MODE_STANDBY;
                        end else begin
                            case (r_area)
                                sahy_pkg::AREA_1: begin
                                    if (w_above_hi) begin
                                        n_area = sahy_pkg::AREA_2;
                                    end else if (w_below_lo) begin
                                        n_area = sahy_pkg::AREA_0;
                                    end else begin
                                        w_hold = 1'b1;
                                        w_lva  = i_cfg.levels[0];
                                        w_lvb  = ~i_cfg.levels[1];
                                    end
                                end
                                sahy_pkg::AREA_2: begin
                                    if (w_below_lo) begin
                                        n_area = sahy_pkg::AREA_0;
                                    end else if (w_below_hi) begin
                                        n_area = sahy_pkg::AREA_1;
                                    end else begin
                                        w_hold = 1'b1;
                                        w_lva  = i_cfg.levels[0];
                                        w_lvb  = i_cfg.levels[1];
                                    end
                                end
                                default: begin
                                    if (w_above_hi) begin
                                        n_area = sahy_pkg::AREA_2;
                                    end else if (w_above_lo) begin
                                        n_area = sahy_pkg::AREA_1;
                                    end else begin
                                        n_area = sahy_pkg::AREA_0;
                                        w_hold = 1'b1;
                                        w_lva  = ~i_cfg.levels[0];
                                        w_lvb  = ~i_cfg.levels[1];
                                    end
                                end
                            endcase
                        end
                    end
                    default: n_mode = sahy_pkg::MODE_STANDBY;
                endcase
            end
            default: ;
        endcase

        n_res.area   = n_area;
        n_res.mode   = n_mode;
        n_res.wa_req = w_hold & w_num_a_ok & (w_bit_a != w_lva);
        n_res.wa_num = n_res.wa_req ? i_cfg.number_a : 4'd0;
        n_res.wa_lvl = n_res.wa_req & w_lva;
        n_res.wb_req = w_hold & w_num_b_ok & (w_bit_b != w_lvb);
        n_res.wb_num = n_res.wb_req ? i_cfg.number_b : 4'd0;
        n_res.wb_lvl = n_res.wb_req & w_lvb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= sahy_pkg::MODE_INIT;
            r_area    <= sahy_pkg::AREA_0;
            r_v2      <= '0;
            r_rb      <= '0;
            r_odo_age <= sahy_pkg::AGE_MAX;
            r_rb_age  <= sahy_pkg::AGE_MAX;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode    <= n_mode;
                r_area    <= n_area;
                r_v2      <= n_v2;
                r_rb      <= n_rb;
                r_odo_age <= n_odo_age;
                r_rb_age  <= n_rb_age;
                r_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule

// File: rtl/speed_area_selector_hysteresis.sv
// Top level of the speed area selector: configuration registers and threshold squares,
// front stage, queue and back stage. Depends on sahy_pkg, sahy_front, sahy_queue, sahy_back.

// The block takes one beat per clock, sustained while the queue has room, and returns one
// result beat for every input beat, in order. A beat is a tick (cmd 0), an odometry sample
// (cmd 1) or an output readback (cmd 2); cmd 3 is passed through as a result with no change.
// An accepted beat is loaded into the front register, which squares the speeds in its single
// multiplier pair, moves to a queue slot and then into the back output register, where all
// state updates and the hysteresis compares happen together; a full queue or an output
// stall can hold the beat between these steps. The two-entry queue lets the input keep
// flowing while the output stalls briefly; once it fills, the input stalls. Threshold
// squares are formed in the cycle of the configuration write, so configuration is ready
// for a beat accepted right after it. There is no clearing pass.

module speed_area_selector_hysteresis #(
    parameter int OUTPUT_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_speed_x,
    input  logic signed [15:0] i_speed_y,
    input  logic [7:0]         i_output_readback,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_area,
    output logic [1:0]         o_mode,
    output logic               o_write_a_request,
    output logic [3:0]         o_write_a_number,
    output logic               o_write_a_level,
    output logic               o_write_b_request,
    output logic [3:0]         o_write_b_number,
    output logic               o_write_b_level
);

    // Raw configuration.
    logic [14:0] r_speed_low, r_speed_high, r_hyst_low, r_hyst_high;
    logic [3:0]  r_number_a, r_number_b;
    logic [1:0]  r_levels;
    logic [15:0] r_stale;
    // Squared thresholds; the fall-back thresholds carry an enable that is low when
    // the limit minus its margin is zero or below.
    logic [29:0] r_low_sq, r_high_sq, r_low_fall_sq, r_high_fall_sq;
    logic        r_low_fall_en, r_high_fall_en;

    logic [14:0] w_new_val;
    logic [15:0] w_low_diff, w_high_diff;
    logic [14:0] w_low_lim, w_low_hyst, w_high_lim, w_high_hyst;
    logic [29:0] w_new_sq, w_low_diff_sq, w_high_diff_sq;

    sahy_pkg::t_cfg    w_cfg;
    sahy_pkg::t_item   w_front_item, w_q_item;
    sahy_pkg::t_result w_res;
    logic              w_push, w_pop, w_q_full, w_q_valid;

    assign w_new_val = i_cfg_data[14:0];
    assign w_new_sq  = 30'(w_new_val * w_new_val);

    // Pick the freshly written value in place of the stored one for the difference.
    assign w_low_lim   = (i_cfg_index == sahy_pkg::REG_SPEED_LIMIT_LOW) ? w_new_val
                                                                         : r_speed_low;
    assign w_low_hyst  = (i_cfg_index == sahy_pkg::REG_HYSTERESIS_LOW) ? w_new_val
                                                                        : r_hyst_low;
    assign w_high_lim  = (i_cfg_index == sahy_pkg::REG_SPEED_LIMIT_HIGH) ? w_new_val
                                                                          : r_speed_high;
    assign w_high_hyst = (i_cfg_index == sahy_pkg::REG_HYSTERESIS_HIGH) ? w_new_val
                                                                         : r_hyst_high;
    assign w_low_diff  = {1'b0, w_low_lim} - {1'b0, w_low_hyst};
    assign w_high_diff = {1'b0, w_high_lim} - {1'b0, w_high_hyst};
    assign w_low_diff_sq  = 30'(w_low_diff[14:0] * w_low_diff[14:0]);
    assign w_high_diff_sq = 30'(w_high_diff[14:0] * w_high_diff[14:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_low    <= sahy_pkg::SPEED_LOW_RST;
            r_speed_high   <= sahy_pkg::SPEED_HIGH_RST;
            r_hyst_low     <= sahy_pkg::HYST_LOW_RST;
            r_hyst_high    <= sahy_pkg::HYST_HIGH_RST;
            r_number_a     <= sahy_pkg::NUMBER_A_RST;
            r_number_b     <= sahy_pkg::NUMBER_B_RST;
            r_levels       <= sahy_pkg::LEVELS_RST;
            r_stale        <= sahy_pkg::STALE_RST;
            r_low_sq       <= sahy_pkg::LOW_SQ_RST;
            r_high_sq      <= sahy_pkg::HIGH_SQ_RST;
            r_low_fall_sq  <= sahy_pkg::LOW_FALL_SQ_RST;
            r_high_fall_sq <= sahy_pkg::HIGH_FALL_SQ_RST;
            r_low_fall_en  <= 1'b1;
            r_high_fall_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sahy_pkg::REG_SPEED_LIMIT_LOW: begin
                    r_speed_low   <= w_new_val;
                    r_low_sq      <= w_new_sq;
                    r_low_fall_sq <= w_low_diff_sq;
                    r_low_fall_en <= ~w_low_diff[15] & (w_low_diff != 16'd0);
                end
                sahy_pkg::REG_SPEED_LIMIT_HIGH: begin
                    r_speed_high   <= w_new_val;
                    r_high_sq      <= w_new_sq;
                    r_high_fall_sq <= w_high_diff_sq;
                    r_high_fall_en <= ~w_high_diff[15] & (w_high_diff != 16'd0);
                end
                sahy_pkg::REG_HYSTERESIS_LOW: begin
                    r_hyst_low    <= w_new_val;
                    r_low_fall_sq <= w_low_diff_sq;
                    r_low_fall_en <= ~w_low_diff[15] & (w_low_diff != 16'd0);
                end
                sahy_pkg::REG_HYSTERESIS_HIGH: begin
                    r_hyst_high    <= w_new_val;
                    r_high_fall_sq <= w_high_diff_sq;
                    r_high_fall_en <= ~w_high_diff[15] & (w_high_diff != 16'd0);
                end
                sahy_pkg::REG_OUTPUT_NUMBER_A: r_number_a <= i_cfg_data[3:0];
                sahy_pkg::REG_OUTPUT_NUMBER_B: r_number_b <= i_cfg_data[3:0];
                sahy_pkg::REG_ACTIVE_LEVELS:   r_levels   <= i_cfg_data[1:0];
                sahy_pkg::REG_STALE_TICKS:     r_stale    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.low_sq       = r_low_sq;
    assign w_cfg.high_sq      = r_high_sq;
    assign w_cfg.low_fall_sq  = r_low_fall_sq;
    assign w_cfg.low_fall_en  = r_low_fall_en;
    assign w_cfg.high_fall_sq = r_high_fall_sq;
    assign w_cfg.high_fall_en = r_high_fall_en;
    assign w_cfg.number_a     = r_number_a;
    assign w_cfg.number_b     = r_number_b;
    assign w_cfg.levels       = r_levels;
    assign w_cfg.stale_ticks  = r_stale;

    sahy_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_speed_x         (i_speed_x),
        .i_speed_y         (i_speed_y),
        .i_output_readback (i_output_readback),
        .i_q_full          (w_q_full),
        .o_push            (w_push),
        .o_item            (w_front_item)
    );

    sahy_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    sahy_back #(
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .i_cfg     (w_cfg),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (w_res)
    );

    assign o_area            = w_res.area;
    assign o_mode            = w_res.mode;
    assign o_write_a_request = w_res.wa_req;
    assign o_write_a_number  = w_res.wa_num;
    assign o_write_a_level   = w_res.wa_lvl;
    assign o_write_b_request = w_res.wb_req;
    assign o_write_b_number  = w_res.wb_num;
    assign o_write_b_level   = w_res.wb_lvl;

`ifndef SYNTHESIS
    // A write request only ever comes out of the ready mode.
    a_req_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_write_a_request || o_write_b_request)
            |-> o_mode == sahy_pkg::MODE_READY)
        else $error("write request outside ready mode");

    // Without a request, number and level read zero.
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_a_request && !o_write_b_request
            |-> o_write_a_number == 4'd0 && o_write_a_level == 1'b0
                && o_write_b_number == 4'd0 && o_write_b_level == 1'b0)
        else $error("write fields set without a request");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("queue overflow");
`endif

endmodule
